@@ hdl/vrrq_pkg.sv @@
`default_nettype none
package vrrq_pkg;

	localparam int STORE_BYTES = 1024;
	localparam int ADDR_W      = $clog2(STORE_BYTES);

	localparam logic [10:0] SIZE_MIN   = 11'd8;
	localparam logic [10:0] SIZE_MAX   = 11'(STORE_BYTES);
	localparam logic [10:0] SIZE_RESET = 11'd1024;
	localparam logic [15:0] WRAP_MARK  = 16'hFFFF;

	localparam logic [2:0] CMD_RESERVE = 3'd0;
	localparam logic [2:0] CMD_WRITE   = 3'd1;
	localparam logic [2:0] CMD_POP     = 3'd2;
	localparam logic [2:0] CMD_SPACE   = 3'd3;
	localparam logic [2:0] CMD_CLEAR   = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_INVALID = 2'd3;

	localparam logic REG_BUFFER_SIZE = 1'b0;

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_MARK0, S_MARK1, S_HDR0, S_HDR1,
		S_POP_H0, S_POP_H1, S_POP_D, S_POP_M0, S_POP_M1
	} seq_state_t;

	typedef struct packed {
		logic [9:0]  length;
		logic [10:0] size;
		logic [10:0] occ;
		logic [9:0]  last_pos;
		logic [9:0]  head;
		logic [10:0] append;
	} place_in_t;

	typedef struct packed {
		logic [1:0] status;
		logic [9:0] pos;
		logic       wrap;
	} place_res_t;

endpackage
`default_nettype wire

@@ hdl/vrrq_req_if.sv @@
`default_nettype none
interface vrrq_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic [9:0] length;
	logic [7:0] data_byte;

	modport source (output valid, command, length, data_byte, input ready);
	modport sink (input valid, command, length, data_byte, output ready);
endinterface
`default_nettype wire

@@ hdl/vrrq_rsp_if.sv @@
`default_nettype none
interface vrrq_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  read_byte;
	logic        last_byte;
	logic [9:0]  record_length;
	logic [9:0]  record_count;
	logic [10:0] used_bytes;

	modport source (output valid, status, read_byte, last_byte, record_length,
		record_count, used_bytes, input ready);
	modport sink (input valid, status, read_byte, last_byte, record_length,
		record_count, used_bytes, output ready);
endinterface
`default_nettype wire

@@ hdl/vrrq_place.sv @@
`default_nettype none
module vrrq_place
	import vrrq_pkg::*;
(
	input  place_in_t  pin,
	output place_res_t pres
);
	logic [10:0] need;
	logic [10:0] tail_room;

	assign need      = {1'b0, pin.length} + 11'd2;
	assign tail_room = pin.size - pin.append;

	always_comb begin
		pres.status = ST_OK;
		pres.pos    = '0;
		pres.wrap   = 1'b0;
		if (pin.length == '0 || need > pin.size) begin
			pres.status = ST_INVALID;
		end else if (pin.size - pin.occ < need) begin
			pres.status = ST_NOSPACE;
		end else if (pin.occ == '0) begin
			pres.status = ST_OK;
		end else if (pin.last_pos >= pin.head) begin
			if (pin.append <= pin.size && tail_room >= need) begin
				pres.pos = pin.append[9:0];
			end else if ({1'b0, pin.head} >= need) begin
				pres.wrap = 1'b1;
			end else begin
				pres.status = ST_NOSPACE;
			end
		end else if ({1'b0, pin.head} >= pin.append &&
				{1'b0, pin.head} - pin.append >= need) begin
			pres.pos = pin.append[9:0];
		end else begin
			pres.status = ST_NOSPACE;
		end
	end
endmodule
`default_nettype wire

@@ hdl/variable_record_ring_queue.sv @@
// Variable-length record ring queue.
// Records sit contiguously in a 1024-byte store, each behind a 2-byte
// little-endian header (payload length + 2); a 0xFFFF marker flags a wrap.
// req channel: one command word (command, length, data_byte), taken when
//   valid and ready are high. ready is high only while the sequencer is idle
//   and the result register is free or being drained in the same cycle.
// rsp channel: exactly one result word per command.
// Sequencer states from accept to result valid, over a byte-wide store
// with one write port and one registered read port:
//   write byte, space check, clear, reserve or pop errors: S_EXEC only
//   pop byte on a zero-length header: S_EXEC, S_POP_H0, S_POP_H1
//   reserve: S_EXEC, then S_MARK0, S_MARK1 for a wrap marker, S_HDR0, S_HDR1
//   pop byte: through S_POP_D; S_POP_M0/M1 check a moved head for a marker
// The next command is taken at the edge that drains the result word; only
// one command is in the sequencer at a time.
// A stalled receiver holds the result word; no new command enters meanwhile.
// APB: buffer_size at address 0; a write clamps to [8,1024] in use and
// empties the queue. Reset (arst_n low) empties the queue and sets
// buffer_size to 1024; store contents are left as they are.
`default_nettype none
module variable_record_ring_queue
	import vrrq_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	vrrq_req_if.sink    req,
	vrrq_rsp_if.source  rsp,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	// store
	logic [7:0]        mem [STORE_BYTES];
	logic [ADDR_W-1:0] raddr, waddr;
	logic [7:0]        wdata, rdata_q;
	logic              we;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// queue state
	seq_state_t  state_q, state_n;
	logic [10:0] bsize_q;
	logic [9:0]  head_q, head_n, last_q, last_n, recs_q, recs_n;
	logic [10:0] app_q, app_n, occ_q, occ_n;
	logic [9:0]  wrem_q, wrem_n, rrem_q, rrem_n;
	// per-command work
	logic [2:0]  cmd_q;
	logic [9:0]  len_q;
	logic [7:0]  dat_q;
	logic [9:0]  pos_q, pos_n, mark_q, mark_n, rrp_q, rrp_n;
	logic [7:0]  lo_q, lo_n;
	logic [15:0] hdr_q, hdr_n;
	// result word
	logic        ov_q, fin;
	logic [1:0]  st_q, st_n;
	logic [7:0]  rb_q, rb_n;
	logic        lb_q, lb_n;
	logic [9:0]  rl_q, rl_n;

	logic        accept, cfg_wr;
	logic [10:0] size;
	place_in_t   pin;
	place_res_t  pres;

	assign accept = (state_q == S_IDLE) && (!ov_q || rsp.ready);
	assign req.ready = accept;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BUFFER_SIZE);
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BUFFER_SIZE) ? {21'd0, bsize_q} : 32'd0;

	assign size = (bsize_q < SIZE_MIN) ? SIZE_MIN :
		((bsize_q > SIZE_MAX) ? SIZE_MAX : bsize_q);

	assign pin.length   = len_q;
	assign pin.size     = size;
	assign pin.occ      = occ_q;
	assign pin.last_pos = last_q;
	assign pin.head     = head_q;
	assign pin.append   = app_q;

	vrrq_place u_place (.pin(pin), .pres(pres));

	logic [15:0] hdr_rd, len16;
	logic [9:0]  rrp_c;
	logic [10:0] need, dptr;
	logic [16:0] hsum;
	logic [10:0] occ_dec;
	logic [9:0]  recs_dec;

	assign need   = {1'b0, len_q} + 11'd2;
	assign hdr_rd = {rdata_q, lo_q};
	assign len16  = (hdr_rd >= 16'd2) ? hdr_rd - 16'd2 : 16'd0;
	assign rrp_c  = (rrem_q == '0 || {6'd0, rrem_q} > len16) ? len16[9:0] : rrem_q;
	assign dptr   = {1'b0, head_q} + 11'd2 + {1'b0, len16[9:0]} - {1'b0, rrp_c};
	assign hsum   = {7'd0, head_q} + {1'b0, hdr_q};
	assign occ_dec = ({5'd0, occ_q} >= hdr_q) ? occ_q - hdr_q[10:0] : 11'd0;
	assign recs_dec = (recs_q != '0) ? recs_q - 10'd1 : 10'd0;

	always_comb begin
		state_n = state_q;
		head_n = head_q; last_n = last_q; app_n = app_q; occ_n = occ_q;
		recs_n = recs_q; wrem_n = wrem_q; rrem_n = rrem_q;
		pos_n = pos_q; mark_n = mark_q; lo_n = lo_q; hdr_n = hdr_q; rrp_n = rrp_q;
		st_n = st_q; rb_n = rb_q; lb_n = lb_q; rl_n = rl_q;
		fin = 1'b0;
		we = 1'b0; waddr = '0; wdata = '0;
		raddr = head_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && req.valid) begin
					state_n = S_EXEC;
				end
			end
			S_EXEC: begin
				st_n = ST_OK; rb_n = '0; lb_n = 1'b0; rl_n = '0;
				state_n = S_IDLE;
				fin = 1'b1;
				case (cmd_q)
					CMD_RESERVE: begin
						if (wrem_q != '0) begin
							st_n = ST_INVALID;
						end else if (pres.status != ST_OK) begin
							st_n = pres.status;
						end else begin
							fin = 1'b0;
							if (occ_q == '0) head_n = '0;
							mark_n = app_q[9:0];
							pos_n = pres.pos;
							last_n = pres.pos;
							app_n = {1'b0, pres.pos} + need;
							occ_n = occ_q + need;
							wrem_n = len_q;
							state_n = (pres.wrap && size - app_q >= 11'd2) ? S_MARK0 : S_HDR0;
						end
					end
					CMD_WRITE: begin
						if (wrem_q == '0) begin
							st_n = ST_INVALID;
						end else begin
							we = 1'b1;
							waddr = app_q[9:0] - wrem_q;
							wdata = dat_q;
							wrem_n = wrem_q - 10'd1;
							if (wrem_q == 10'd1) recs_n = recs_q + 10'd1;
						end
					end
					CMD_POP: begin
						if (wrem_q != '0) begin
							st_n = ST_INVALID;
						end else if (rrem_q == '0 && recs_q == '0) begin
							st_n = ST_EMPTY;
						end else begin
							fin = 1'b0;
							raddr = head_q;
							state_n = S_POP_H0;
						end
					end
					CMD_SPACE: st_n = pres.status;
					CMD_CLEAR: begin
						head_n = '0; last_n = '0; app_n = '0; occ_n = '0;
						recs_n = '0; wrem_n = '0; rrem_n = '0;
					end
					default: st_n = ST_INVALID;
				endcase
			end
			S_MARK0: begin
				we = 1'b1; waddr = mark_q; wdata = WRAP_MARK[7:0];
				state_n = S_MARK1;
			end
			S_MARK1: begin
				we = 1'b1; waddr = mark_q + 10'd1; wdata = WRAP_MARK[15:8];
				state_n = S_HDR0;
			end
			S_HDR0: begin
				we = 1'b1; waddr = pos_q; wdata = need[7:0];
				state_n = S_HDR1;
			end
			S_HDR1: begin
				we = 1'b1; waddr = pos_q + 10'd1; wdata = {5'd0, need[10:8]};
				state_n = S_IDLE;
				fin = 1'b1;
			end
			S_POP_H0: begin
				lo_n = rdata_q;
				raddr = head_q + 10'd1;
				state_n = S_POP_H1;
			end
			S_POP_H1: begin
				rl_n = len16[9:0];
				hdr_n = hdr_rd;
				rrp_n = rrp_c;
				rrem_n = rrp_c;
				raddr = dptr[9:0];
				if (rrp_c == '0) begin
					st_n = ST_INVALID;
					state_n = S_IDLE;
					fin = 1'b1;
				end else begin
					state_n = S_POP_D;
				end
			end
			S_POP_D: begin
				rb_n = rdata_q;
				rrem_n = rrp_q - 10'd1;
				state_n = S_IDLE;
				fin = 1'b1;
				if (rrp_q == 10'd1) begin
					lb_n = 1'b1;
					occ_n = occ_dec;
					recs_n = recs_dec;
					head_n = hsum[9:0];
					raddr = hsum[9:0];
					if (recs_dec == '0 || occ_dec == '0) begin
						head_n = '0; last_n = '0; app_n = '0; occ_n = '0;
					end else if (hsum >= {6'd0, size} || {6'd0, size} - hsum < 17'd2) begin
						head_n = '0;
					end else begin
						fin = 1'b0;
						state_n = S_POP_M0;
					end
				end
			end
			S_POP_M0: begin
				lo_n = rdata_q;
				raddr = head_q + 10'd1;
				state_n = S_POP_M1;
			end
			S_POP_M1: begin
				if (hdr_rd == WRAP_MARK) head_n = '0;
				state_n = S_IDLE;
				fin = 1'b1;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bsize_q <= SIZE_RESET;
			head_q <= '0; last_q <= '0; app_q <= '0; occ_q <= '0;
			recs_q <= '0; wrem_q <= '0; rrem_q <= '0;
			ov_q <= 1'b0;
		end else if (cfg_wr) begin
			// must only be written while idle; the block does not enforce it
			bsize_q <= pwdata[10:0];
			head_q <= '0; last_q <= '0; app_q <= '0; occ_q <= '0;
			recs_q <= '0; wrem_q <= '0; rrem_q <= '0;
		end else begin
			state_q <= state_n;
			head_q <= head_n; last_q <= last_n; app_q <= app_n; occ_q <= occ_n;
			recs_q <= recs_n; wrem_q <= wrem_n; rrem_q <= rrem_n;
			if (fin) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req.valid) begin
			cmd_q <= req.command;
			len_q <= req.length;
			dat_q <= req.data_byte;
		end
		pos_q <= pos_n; mark_q <= mark_n; lo_q <= lo_n; hdr_q <= hdr_n; rrp_q <= rrp_n;
		st_q <= st_n; rb_q <= rb_n; lb_q <= lb_n; rl_q <= rl_n;
	end

	assign rsp.valid         = ov_q;
	assign rsp.status        = st_q;
	assign rsp.read_byte     = rb_q;
	assign rsp.last_byte     = lb_q;
	assign rsp.record_length = rl_q;
	assign rsp.record_count  = recs_q;
	assign rsp.used_bytes    = occ_q;
endmodule
`default_nettype wire
